FILE: rtl/biou_nms_pkg.sv
// ----------------------------------------------------------------------------
// Box IoU non-maximum suppression: shared package
// Field widths, result codes, sequencer states and the compare result group.
// ----------------------------------------------------------------------------
package biou_nms_pkg;

   localparam int LABEL_W = 16;
   localparam int CONF_W  = 16;
   localparam int FIELD_W = 16;
   localparam int THR_W   = 8;
   localparam int SLOT_W  = 6;
   localparam int TOTAL_W = 7;

   localparam logic [THR_W-1:0] THR_RESET = 8'd128;

   typedef enum logic [1:0] {
      DEC_APPENDED   = 2'd0,
      DEC_REPLACED   = 2'd1,
      DEC_SUPPRESSED = 2'd2,
      DEC_DROPPED    = 2'd3
   } decision_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic greater;
   } cmp_result_type;

endpackage

FILE: rtl/box_iou_non_max_suppression.sv
// ----------------------------------------------------------------------------
// Box IoU non-maximum suppression
// Keeps a table of detection boxes and decides per request whether the box is
// appended, replaces an overlapping weaker entry, is suppressed, or dropped.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  req_     in         req_tvalid / req_tready   tdata: box, tuser: new_frame
//  rsp_     out        rsp_tvalid / rsp_tready   tdata: decision, slot, total
//  csr_     in         csr_wr_en                 csr_wr_data: iou_threshold
//
// A match ends the walk over the table at the first hit; with no match every kept entry
// is compared in turn, and an empty table goes straight to the decision.
// One entry per cycle goes from the table memory into the four-stage compare unit.
// A new request can be taken in the cycle after the result has been delivered.
// Reset clears the entry count and sets the threshold to 128, not the table contents.
// A stalled result holds in its output register until rsp_tready is seen.
module box_iou_non_max_suppression
   import biou_nms_pkg::*;
#(
   parameter int MAX_BOXES  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // label[15:0], confidence[31:16], top_edge[47:32], bottom_edge[63:48],
   // left_edge[79:64], right_edge[95:80]
   input  logic [95:0]  req_tdata,
   // new_frame[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // decision[1:0], slot[7:2], kept_total[14:8], zero[15]
   output logic [15:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int BOX_W = LABEL_W + CONF_W + 4 * COORD_BITS;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [BOX_W-1:0]      rd_data_ff;
   logic                  found_ff, found_in;
   logic                  found_gt_ff, found_gt_in;
   logic [IDX_W-1:0]      found_idx_ff, found_idx_in;
   logic [THR_W-1:0]      thr_ff;

   logic [LABEL_W-1:0]    nb_label_ff;
   logic [CONF_W-1:0]     nb_conf_ff;
   logic [COORD_BITS-1:0] nb_top_ff, nb_bottom_ff, nb_left_ff, nb_right_ff;

   decision_type          rsp_dec_ff, rsp_dec_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;

   logic [BOX_W-1:0]      kept_mem_ff [MAX_BOXES];
   logic                  mem_we, mem_re;
   logic [IDX_W-1:0]      mem_waddr;
   logic                  req_accept, flush, unit_busy;
   cmp_result_type        unit_res;
   logic [IDX_W-1:0]      unit_idx;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_slot_ff, rsp_dec_ff};
   assign flush      = (state_ff != ST_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         nb_label_ff  <= req_tdata[15:0];
         nb_conf_ff   <= req_tdata[31:16];
         nb_top_ff    <= COORD_BITS'(req_tdata[47:32]);
         nb_bottom_ff <= COORD_BITS'(req_tdata[63:48]);
         nb_left_ff   <= COORD_BITS'(req_tdata[79:64]);
         nb_right_ff  <= COORD_BITS'(req_tdata[95:80]);
      end
   end

   // Table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kept_mem_ff[mem_waddr] <= {nb_right_ff, nb_left_ff, nb_bottom_ff, nb_top_ff,
                                    nb_conf_ff, nb_label_ff};
      end
      if (mem_re) begin
         rd_data_ff <= kept_mem_ff[issue_ff[IDX_W-1:0]];
      end
      rd_idx_ff <= issue_ff[IDX_W-1:0];
   end

   biou_nms_iou_unit #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_iou (
      .clock       (clock),
      .reset       (reset),
      .flush       (flush),
      .in_valid    (rd_vld_ff),
      .in_idx      (rd_idx_ff),
      .threshold   (thr_ff),
      .new_label   (nb_label_ff),
      .new_conf    (nb_conf_ff),
      .new_top     (nb_top_ff),
      .new_bottom  (nb_bottom_ff),
      .new_left    (nb_left_ff),
      .new_right   (nb_right_ff),
      .kept_label  (rd_data_ff[LABEL_W-1:0]),
      .kept_conf   (rd_data_ff[LABEL_W+CONF_W-1:LABEL_W]),
      .kept_top    (rd_data_ff[LABEL_W+CONF_W+COORD_BITS-1:LABEL_W+CONF_W]),
      .kept_bottom (rd_data_ff[LABEL_W+CONF_W+2*COORD_BITS-1:LABEL_W+CONF_W+COORD_BITS]),
      .kept_left   (rd_data_ff[LABEL_W+CONF_W+3*COORD_BITS-1:LABEL_W+CONF_W+2*COORD_BITS]),
      .kept_right  (rd_data_ff[BOX_W-1:LABEL_W+CONF_W+3*COORD_BITS]),
      .result      (unit_res),
      .result_idx  (unit_idx),
      .busy        (unit_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      found_gt_ff  <= found_gt_in;
      found_idx_ff <= found_idx_in;
      rsp_dec_ff   <= rsp_dec_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      found_gt_in  = found_gt_ff;
      found_idx_in = found_idx_ff;
      rsp_dec_in   = rsp_dec_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_total_in = rsp_total_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = found_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
               issue_in = '0;
               found_in = 1'b0;
               if (req_tuser) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN: begin
            // Results come back in table order, so the first hit is the earliest match.
            if (unit_res.valid && unit_res.hit) begin
               found_in     = 1'b1;
               found_gt_in  = unit_res.greater;
               found_idx_in = unit_idx;
               state_in     = ST_DECIDE;
            end else if (issue_ff < count_ff) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
            end else if (!rd_vld_ff && !unit_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               if (found_gt_ff) begin
                  rsp_dec_in  = DEC_REPLACED;
                  rsp_slot_in = SLOT_W'(found_idx_ff);
                  mem_we      = 1'b1;
               end else begin
                  rsp_dec_in  = DEC_SUPPRESSED;
                  rsp_slot_in = '0;
               end
            end else if (count_ff < CNT_W'(MAX_BOXES)) begin
               rsp_dec_in  = DEC_APPENDED;
               rsp_slot_in = SLOT_W'(count_ff);
               mem_we      = 1'b1;
               mem_waddr   = count_ff[IDX_W-1:0];
               count_in    = count_ff + CNT_W'(1);
            end else begin
               rsp_dec_in  = DEC_DROPPED;
               rsp_slot_in = '0;
            end
            rsp_total_in = TOTAL_W'(count_in);
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BOXES))
      else $error("kept count exceeds table size");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !found_ff && count_ff < CNT_W'(MAX_BOXES))
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance the kept count");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && found_ff) |-> CNT_W'(found_idx_ff) < count_ff)
      else $error("matched entry lies beyond the kept count");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is pending");

endmodule

FILE: rtl/biou_nms_iou_unit.sv
// ----------------------------------------------------------------------------
// Box IoU non-maximum suppression: overlap compare unit
// Four-stage pipelined IoU test of the new box against one kept entry per cycle.
// ----------------------------------------------------------------------------
module biou_nms_iou_unit
   import biou_nms_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int IDX_W      = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  logic                  in_valid,
   input  logic [IDX_W-1:0]      in_idx,
   input  logic [THR_W-1:0]      threshold,
   input  logic [LABEL_W-1:0]    new_label,
   input  logic [CONF_W-1:0]     new_conf,
   input  logic [COORD_BITS-1:0] new_top,
   input  logic [COORD_BITS-1:0] new_bottom,
   input  logic [COORD_BITS-1:0] new_left,
   input  logic [COORD_BITS-1:0] new_right,
   input  logic [LABEL_W-1:0]    kept_label,
   input  logic [CONF_W-1:0]     kept_conf,
   input  logic [COORD_BITS-1:0] kept_top,
   input  logic [COORD_BITS-1:0] kept_bottom,
   input  logic [COORD_BITS-1:0] kept_left,
   input  logic [COORD_BITS-1:0] kept_right,
   output cmp_result_type        result,
   output logic [IDX_W-1:0]      result_idx,
   output logic                  busy
);

   localparam int D = COORD_BITS + 1;
   localparam int P = 2 * D;
   localparam int U = P + 2;
   localparam int M = U + THR_W + 1;

   logic [COORD_BITS-1:0] min_right, max_left, min_bottom, max_top;
   logic signed [D-1:0]   iw_in, ih_in, wn_in, hn_in, wk_in, hk_in;

   logic                  s1_vld_ff, s1_same_ff, s1_gt_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic signed [D-1:0]   s1_iw_ff, s1_ih_ff, s1_wn_ff, s1_hn_ff, s1_wk_ff, s1_hk_ff;

   logic                  s2_vld_ff, s2_cand_ff, s2_gt_ff;
   logic [IDX_W-1:0]      s2_idx_ff;
   logic signed [P-1:0]   s2_inter_ff, s2_an_ff, s2_ak_ff;

   logic                  s3_vld_ff, s3_cand_ff, s3_gt_ff;
   logic [IDX_W-1:0]      s3_idx_ff;
   logic signed [P-1:0]   s3_inter_ff;
   logic signed [U-1:0]   s3_uni_ff;

   logic signed [M-1:0]   scaled_inter, scaled_uni;
   logic                  hit_in;
   logic                  res_vld_ff, res_hit_ff, res_gt_ff;
   logic [IDX_W-1:0]      res_idx_ff;

   always_comb begin
      min_right  = (new_right < kept_right) ? new_right : kept_right;
      max_left   = (new_left > kept_left) ? new_left : kept_left;
      min_bottom = (new_bottom < kept_bottom) ? new_bottom : kept_bottom;
      max_top    = (new_top > kept_top) ? new_top : kept_top;
      iw_in = $signed({1'b0, min_right}) - $signed({1'b0, max_left});
      ih_in = $signed({1'b0, min_bottom}) - $signed({1'b0, max_top});
      wn_in = $signed({1'b0, new_right}) - $signed({1'b0, new_left});
      hn_in = $signed({1'b0, new_bottom}) - $signed({1'b0, new_top});
      wk_in = $signed({1'b0, kept_right}) - $signed({1'b0, kept_left});
      hk_in = $signed({1'b0, kept_bottom}) - $signed({1'b0, kept_top});
   end

   // Final stage: inter * 256 against threshold * union, both sign-extended.
   always_comb begin
      scaled_inter = M'(s3_inter_ff) <<< 8;
      scaled_uni   = M'($signed({1'b0, threshold})) * M'(s3_uni_ff);
      hit_in       = s3_cand_ff && (s3_uni_ff > 0) && (scaled_inter > scaled_uni);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         s3_vld_ff       <= 1'b0;
         res_vld_ff      <= 1'b0;
      end else begin
         s1_vld_ff       <= in_valid;
         s2_vld_ff       <= s1_vld_ff;
         s3_vld_ff       <= s2_vld_ff;
         res_vld_ff      <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= in_idx;
      s1_same_ff  <= (new_label == kept_label);
      s1_gt_ff    <= (new_conf > kept_conf);
      s1_iw_ff    <= iw_in;
      s1_ih_ff    <= ih_in;
      s1_wn_ff    <= wn_in;
      s1_hn_ff    <= hn_in;
      s1_wk_ff    <= wk_in;
      s1_hk_ff    <= hk_in;

      s2_idx_ff   <= s1_idx_ff;
      s2_gt_ff    <= s1_gt_ff;
      s2_cand_ff  <= s1_same_ff && (s1_iw_ff > 0) && (s1_ih_ff > 0);
      s2_inter_ff <= P'(s1_iw_ff) * P'(s1_ih_ff);
      s2_an_ff    <= P'(s1_wn_ff) * P'(s1_hn_ff);
      s2_ak_ff    <= P'(s1_wk_ff) * P'(s1_hk_ff);

      s3_idx_ff   <= s2_idx_ff;
      s3_gt_ff    <= s2_gt_ff;
      s3_cand_ff  <= s2_cand_ff;
      s3_inter_ff <= s2_inter_ff;
      s3_uni_ff   <= U'(s2_an_ff) + U'(s2_ak_ff) - U'(s2_inter_ff);

      res_idx_ff  <= s3_idx_ff;
      res_hit_ff  <= hit_in;
      res_gt_ff   <= s3_gt_ff;
   end

   assign result     = '{valid: res_vld_ff, hit: res_hit_ff, greater: res_gt_ff};
   assign result_idx = res_idx_ff;
   assign busy       = s1_vld_ff || s2_vld_ff || s3_vld_ff || res_vld_ff;

endmodule
